// ----- sv/gwma_pkg.sv -----
package gwma_pkg;

    localparam int WINDOW       = 8;
    localparam int SAMPLE_WIDTH = 32;

    localparam int PTR_WIDTH  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_WIDTH = $clog2(WINDOW + 1);
    localparam int SUM_WIDTH  = SAMPLE_WIDTH + PTR_WIDTH;
    localparam int CNT_WIDTH  = $clog2(SUM_WIDTH);
    localparam int AVG_WIDTH  = 32;
    localparam int HELD_WIDTH = 4;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] speed_sample;
        logic                           clear_first;
    } in_item_t;

    typedef struct packed {
        logic signed [AVG_WIDTH-1:0] average_speed;
        logic [HELD_WIDTH-1:0]       samples_held;
    } out_item_t;

    typedef struct packed {
        logic signed [SUM_WIDTH-1:0] sum;
        logic [FILL_WIDTH-1:0]       fill;
    } hist_status_t;

    typedef struct packed {
        logic                  start;
        logic [SUM_WIDTH-1:0]  dividend;
        logic [FILL_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [SUM_WIDTH-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_DONE
    } state_t;

endpackage

// ----- sv/gwma_history.sv -----
module gwma_history
    import gwma_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         take,
    input  in_item_t     item,
    output hist_status_t status
);

    logic [SAMPLE_WIDTH-1:0] hist_reg [WINDOW];
    logic [WINDOW-1:0]       valid_reg, valid_next;
    logic [PTR_WIDTH-1:0]    pos_reg, pos_next, pos_base;
    logic [FILL_WIDTH-1:0]   fill_reg, fill_next, fill_base;
    logic signed [SUM_WIDTH-1:0] sum_reg, sum_next, sum_base, old_ext, new_ext;

    always_comb begin
        pos_base  = item.clear_first ? '0 : pos_reg;
        fill_base = item.clear_first ? '0 : fill_reg;
        sum_base  = item.clear_first ? '0 : sum_reg;
        // An entry not written since the last clear reads as zero.
        if (!item.clear_first && valid_reg[pos_base]) begin
            old_ext = SUM_WIDTH'(signed'(hist_reg[pos_base]));
        end else begin
            old_ext = '0;
        end
        new_ext = SUM_WIDTH'(signed'(item.speed_sample));

        sum_next  = sum_base - old_ext + new_ext;
        pos_next  = (pos_base == PTR_WIDTH'(WINDOW - 1)) ? '0 : pos_base + 1'b1;
        fill_next = (fill_base == FILL_WIDTH'(WINDOW)) ? fill_base : fill_base + 1'b1;
        valid_next = item.clear_first ? '0 : valid_reg;
        valid_next[pos_base] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            pos_reg   <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end else if (take) begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            hist_reg[pos_base] <= item.speed_sample;
        end
    end

    assign status.sum  = sum_reg;
    assign status.fill = fill_reg;

endmodule

// ----- sv/gwma_divider.sv -----
module gwma_divider
    import gwma_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of quo_reg while quotient bits shift in at the bottom.
    logic [SUM_WIDTH-1:0]  quo_reg, quo_next;
    logic [FILL_WIDTH-1:0] rem_reg, rem_next;
    logic [FILL_WIDTH-1:0] dsr_reg;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [FILL_WIDTH:0]   trial;
    logic                  fits;

    always_comb begin
        trial = {rem_reg, quo_reg[SUM_WIDTH-1]};
        fits  = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? FILL_WIDTH'(trial - {1'b0, dsr_reg}) : trial[FILL_WIDTH-1:0];
        quo_next = {quo_reg[SUM_WIDTH-2:0], fits};
        cnt_next  = cnt_reg + 1'b1;
        busy_next = (cnt_reg != CNT_WIDTH'(SUM_WIDTH - 1));
        done_next = busy_reg && !busy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- sv/growing_window_moving_average_top.sv -----
// Channel   Ports                       Payload
// input     s_valid, s_ready, s_item    speed_sample, clear_first
// result    m_valid, m_ready, m_item    average_speed, samples_held
//
// One request is taken at a time, in the idle state only. Its accept edge updates the ring,
// the running sum and the fill count; in the next cycle (ST_LOAD) the magnitude of the sum
// enters a bit-serial divider that works through every bit of the sum (SUM_WIDTH, 35 by
// default). On its done flag the block enters its final state, loads the result register once
// the output register is free and returns to idle; no new request is taken before then.
// Reset (aresetn, synchronous, active low) empties the ring through per-entry valid bits.
// A stalled result holds the block in its final state until the output register frees up.
module growing_window_moving_average_top
    import gwma_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    state_t       state_reg, state_next;
    hist_status_t status;
    div_req_t     div_req;
    div_rsp_t     div_rsp;

    logic      take;
    logic      out_free;
    logic      load_out;
    logic      neg_reg, neg_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg;
    logic [SUM_WIDTH-1:0] sum_mag;
    logic [AVG_WIDTH-1:0] quo_low;

    assign take     = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    gwma_history u_history (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (s_item),
        .status  (status)
    );

    // The divider works on the magnitude; the sign is put back at the end so
    // that the quotient truncates toward zero.
    always_comb begin
        sum_mag  = status.sum[SUM_WIDTH-1] ? SUM_WIDTH'(-status.sum) : SUM_WIDTH'(status.sum);
        neg_next = status.sum[SUM_WIDTH-1];
    end

    gwma_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        s_ready          = 1'b0;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = sum_mag;
        div_req.divisor  = status.fill;
        unique case (state_reg)
            ST_IDLE:   s_ready       = 1'b1;
            ST_LOAD:   div_req.start = 1'b1;
            ST_DIVIDE: ;
            ST_DONE:   load_out      = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            neg_reg <= neg_next;
        end
    end

    always_comb begin
        quo_low = div_rsp.quotient[AVG_WIDTH-1:0];
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_item_reg.average_speed <= neg_reg ? -quo_low : quo_low;
            m_item_reg.samples_held  <= HELD_WIDTH'(status.fill);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
